// File: sv/sntm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sntm_pkg
// Shared types and constants of the square/noise tone mixer.
// ----------------------------------------------------------------------------
package sntm_pkg;

  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_WRITE   = 3'd1;
  localparam logic [2:0] REQ_NOTE    = 3'd2;
  localparam logic [2:0] REQ_SILENCE = 3'd3;
  localparam logic [2:0] REQ_RETUNE  = 3'd4;

  localparam logic [7:0] LCG_MUL = 8'd67;
  localparam logic [7:0] LCG_ADD = 8'd71;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MODW,
    ST_MIX,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

// File: sv/sntm_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sntm_mod
// Iterative 8-bit remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sntm_mod import sntm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [7:0] dividend,
  input  wire logic [7:0] divisor,
  output logic            done,
  output logic [7:0]      rem
);

  logic       busy;
  logic [2:0] cnt;
  logic [7:0] shft;
  logic [7:0] dsr;
  logic [8:0] trial;
  logic [7:0] diff;

  assign trial = {rem, shft[7]};
  assign diff  = trial[7:0] - dsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= 8'd0;
      shft <= dividend;
      dsr  <= divisor;
    end else if (busy) begin
      shft <= {shft[6:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= diff;
      end else begin
        rem <= trial[7:0];
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/square_noise_tone_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// square_noise_tone_mixer
// Multi-channel square/noise tone generator with an 8-bit PWM mix level.
// ----------------------------------------------------------------------------
// Channel  Direction  Content
// s_*      in         request: tuser = req_type, tdata = channel, half_period,
//                     amplitude, noise_on
// m_*      out        result: tdata = mix_level, tuser = level_changed
//
// One request is processed at a time; s_tready is high only while idle.
// A tick steps through the channels one per cycle, except that a noise toggle
// waits in ST_MODW for the serial remainder unit. A remix steps through every
// channel in ST_MIX and sums the levels of those whose phase is high.
// Reset is synchronous and clears all channel state; the seed resets to one.
// A result waiting on m_tready holds the block in its final state.
// ----------------------------------------------------------------------------
module square_noise_tone_mixer import sntm_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // channel[1:0], half_period[9:2],
                                      // amplitude[17:10], noise_on[18]
  input  wire logic [2:0]  s_tuser,   // req_type[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // mix_level[7:0]
  output logic [0:0]       m_tuser    // level_changed[0]
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t state, state_next;

  logic [7:0] tick_count   [CHANNELS];
  logic       phase_high   [CHANNELS];
  logic [7:0] half_periods [CHANNELS];
  logic [7:0] amplitudes   [CHANNELS];
  logic [7:0] levels       [CHANNELS];
  logic       noise_enable [CHANNELS];
  logic [7:0] noise_seed;
  logic [7:0] pwm_level;

  logic [2:0]      req;
  logic [7:0]      req_hp;
  logic [7:0]      req_amp;
  logic            req_nz;
  logic [CH_W-1:0] ch_idx;
  logic            toggled;
  logic            changed;
  logic [7:0]      sum;

  logic [1:0]  in_ch;
  logic        req_ok;
  logic        last;
  logic        active;
  logic [7:0]  cnt_inc;
  logic        hit;
  logic [7:0]  seed_adv;
  logic [7:0]  sum_add;
  logic        div_start;
  logic        div_done;
  logic [7:0]  div_rem;
  logic        advance;

  assign in_ch     = s_tdata[1:0];
  assign req_ok    = (s_tuser == REQ_TICK) ||
                     ((s_tuser inside {[REQ_WRITE:REQ_RETUNE]}) && (32'(in_ch) < CHANNELS));
  assign last      = (ch_idx == CH_W'(CHANNELS - 1));
  assign active    = (amplitudes[ch_idx] != 8'd0);
  assign cnt_inc   = tick_count[ch_idx] + 8'd1;
  assign hit       = (cnt_inc >= half_periods[ch_idx]);
  assign seed_adv  = noise_seed * LCG_MUL + LCG_ADD;
  assign sum_add   = sum + (phase_high[ch_idx] ? levels[ch_idx] : 8'd0);
  assign s_tready  = (state == ST_IDLE);

  sntm_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (seed_adv),
    .divisor  (amplitudes[ch_idx]),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    advance    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = req_ok ? ST_EXEC : ST_FINISH;
        end
      end
      ST_EXEC: begin
        case (req)
          REQ_TICK: begin
            if (active && hit && noise_enable[ch_idx]) begin
              div_start  = 1'b1;
              state_next = ST_MODW;
            end else if (last) begin
              state_next = (toggled || (active && hit)) ? ST_MIX : ST_FINISH;
            end else begin
              advance = 1'b1;
            end
          end
          REQ_SILENCE, REQ_RETUNE: state_next = ST_MIX;
          default: state_next = ST_FINISH;
        endcase
      end
      ST_MODW: begin
        if (div_done) begin
          if (last) begin
            state_next = ST_MIX;
          end else begin
            advance    = 1'b1;
            state_next = ST_EXEC;
          end
        end
      end
      ST_MIX: begin
        if (last) begin
          state_next = ST_FINISH;
        end else begin
          advance = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        tick_count[c]   <= 8'd0;
        phase_high[c]   <= 1'b0;
        half_periods[c] <= 8'd0;
        amplitudes[c]   <= 8'd0;
        levels[c]       <= 8'd0;
        noise_enable[c] <= 1'b0;
      end
      noise_seed <= 8'd1;
      pwm_level  <= 8'd0;
      m_tvalid   <= 1'b0;
      changed    <= 1'b0;
      toggled    <= 1'b0;
      ch_idx     <= '0;
    end else begin
      if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (advance) begin
        ch_idx <= ch_idx + CH_W'(1);
      end
      if (state_next == ST_MIX && state != ST_MIX) begin
        ch_idx <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            changed <= 1'b0;
            toggled <= 1'b0;
            ch_idx  <= (s_tuser == REQ_TICK) ? '0 : in_ch[CH_W-1:0];
          end
        end
        ST_EXEC: begin
          case (req)
            REQ_TICK: begin
              if (active) begin
                if (hit) begin
                  toggled            <= 1'b1;
                  phase_high[ch_idx] <= ~phase_high[ch_idx];
                  tick_count[ch_idx] <= 8'd0;
                  if (noise_enable[ch_idx]) begin
                    noise_seed <= seed_adv;
                  end
                end else begin
                  tick_count[ch_idx] <= cnt_inc;
                end
              end
            end
            REQ_WRITE: begin
              half_periods[ch_idx] <= req_hp;
              amplitudes[ch_idx]   <= req_amp;
              levels[ch_idx]       <= req_amp;
              noise_enable[ch_idx] <= req_nz;
            end
            REQ_NOTE: begin
              phase_high[ch_idx] <= 1'b1;
            end
            REQ_SILENCE: begin
              levels[ch_idx]     <= 8'd0;
              amplitudes[ch_idx] <= 8'd0;
              phase_high[ch_idx] <= 1'b0;
            end
            REQ_RETUNE: begin
              half_periods[ch_idx] <= req_hp;
              phase_high[ch_idx]   <= 1'b0;
              tick_count[ch_idx]   <= 8'd0;
            end
            default: begin
            end
          endcase
        end
        ST_MODW: begin
          if (div_done) begin
            levels[ch_idx] <= div_rem;
          end
        end
        ST_MIX: begin
          if (last) begin
            pwm_level <= sum_add;
            changed   <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      req     <= s_tuser;
      req_hp  <= s_tdata[9:2];
      req_amp <= s_tdata[17:10];
      req_nz  <= s_tdata[18];
    end
    if (state_next == ST_MIX && state != ST_MIX) begin
      sum <= 8'd0;
    end else if (state == ST_MIX) begin
      sum <= sum_add;
    end
    if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
      m_tdata    <= pwm_level;
      m_tuser[0] <= changed;
    end
  end

endmodule
`default_nettype wire

// File: verif/sntm_mix_checker.sv
// ----------------------------------------------------------------------------
// sntm_mix_checker
// Watches the request and result streams of the square/noise tone mixer. It
// keeps its own copy of the channel state to predict the mix level and the
// remix flag of every accepted request, and compares each result transfer
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module sntm_mix_checker import sntm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // channel[1:0], half_period[9:2],
                                 // amplitude[17:10], noise_on[18]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // mix_level[7:0]
  input  logic [0:0]  m_tuser,   // level_changed[0]
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output int          remix_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS = 4;

  typedef struct packed {
    logic [7:0] mix;
    logic       changed;
  } mix_result_t;

  logic [7:0] tick_cnt [CHANNELS];
  logic       phase    [CHANNELS];
  logic [7:0] half_per [CHANNELS];
  logic [7:0] amp_r    [CHANNELS];
  logic [7:0] level    [CHANNELS];
  logic       noise_en [CHANNELS];
  logic [7:0] rand_seed;
  logic [7:0] mix_now;

  mix_result_t mix_expected_q [$];

  task automatic clear_channels();
    for (int c = 0; c < CHANNELS; c++) begin
      tick_cnt[c] = 8'd0;
      phase[c]    = 1'b0;
      half_per[c] = 8'd0;
      amp_r[c]    = 8'd0;
      level[c]    = 8'd0;
      noise_en[c] = 1'b0;
    end
    rand_seed = 8'd1;
    mix_now   = 8'd0;
  endtask

  function automatic logic [7:0] sum_active_levels();
    logic [7:0] sum;
    sum = 8'd0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (phase[c]) begin
        sum = sum + level[c];
      end
    end
    return sum;
  endfunction

  function automatic logic step_channels();
    logic toggled;
    toggled = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (amp_r[c] != 8'd0) begin
        tick_cnt[c] = tick_cnt[c] + 8'd1;
        if (tick_cnt[c] >= half_per[c]) begin
          toggled     = 1'b1;
          phase[c]    = ~phase[c];
          tick_cnt[c] = 8'd0;
          if (noise_en[c]) begin
            rand_seed = rand_seed * LCG_MUL + LCG_ADD;
            level[c]  = rand_seed % amp_r[c];
          end
        end
      end
    end
    return toggled;
  endfunction

  function automatic mix_result_t apply_request(logic [2:0] req, logic [1:0] ch,
                                                logic [7:0] hp, logic [7:0] amp,
                                                logic nz);
    logic changed;
    changed = 1'b0;
    case (req)
      REQ_TICK: begin
        if (step_channels()) begin
          mix_now = sum_active_levels();
          changed = 1'b1;
        end
      end
      REQ_WRITE: begin
        half_per[ch] = hp;
        amp_r[ch]    = amp;
        level[ch]    = amp;
        noise_en[ch] = nz;
      end
      REQ_NOTE: begin
        phase[ch] = 1'b1;
      end
      REQ_SILENCE: begin
        level[ch] = 8'd0;
        amp_r[ch] = 8'd0;
        phase[ch] = 1'b0;
        mix_now   = sum_active_levels();
        changed   = 1'b1;
      end
      REQ_RETUNE: begin
        half_per[ch] = hp;
        phase[ch]    = 1'b0;
        tick_cnt[ch] = 8'd0;
        mix_now      = sum_active_levels();
        changed      = 1'b1;
      end
      default: begin
      end
    endcase
    return '{mix: mix_now, changed: changed};
  endfunction

  function automatic void report_failure(string what, mix_result_t want, mix_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s: expected mix %0d changed %0b, got mix %0d changed %0b",
               $realtime, what, want.mix, want.changed, got.mix, got.changed);
    end
  endfunction

  always @(posedge clk) begin
    mix_result_t got;
    mix_result_t want;
    if (rst) begin
      clear_channels();
      mix_expected_q.delete();
      fail_count      = 0;
      results_checked = 0;
      remix_seen      = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{mix: m_tdata, changed: m_tuser[0]};
        results_checked++;
        if (got.changed) begin
          remix_seen++;
        end
        if (mix_expected_q.size() == 0) begin
          report_failure("result transfer with no request waiting", '0, got);
        end else begin
          want = mix_expected_q.pop_front();
          if (got != want) begin
            report_failure("mix result mismatch", want, got);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        mix_expected_q.push_back(apply_request(s_tuser, s_tdata[1:0], s_tdata[9:2],
                                               s_tdata[17:10], s_tdata[18]));
      end
    end
    pending = mix_expected_q.size();
  end

endmodule

// File: verif/square_noise_tone_mixer_tb.sv
// ----------------------------------------------------------------------------
// square_noise_tone_mixer_tb
// Drives requests into the tone mixer: a directed opening over the field
// extremes and corner cases, then weighted random requests with random gaps
// on the request side and random stalls on the result side. A checker module
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module square_noise_tone_mixer_tb import sntm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;
  localparam int RANDOM_ITEMS = 1160;
  localparam int CALM_ITEMS   = 150;
  localparam int LONG_HOLD    = 300;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // channel[1:0], half_period[9:2], amplitude[17:10],
                          // noise_on[18]
  logic [2:0]  s_tuser;   // req_type[2:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // mix_level[7:0]
  logic [0:0]  m_tuser;   // level_changed[0]

  int fail_count;
  int pending;
  int results_checked;
  int remix_seen;

  bit idle_on = 1'b1;
  bit hold_output = 1'b0;
  int gap_pct = 0;
  int sent_by_type [8];

  always #2 clk = ~clk;

  square_noise_tone_mixer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  sntm_mix_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .remix_seen      (remix_seen)
  );

  task automatic send_request(input logic [2:0] req, input logic [1:0] ch,
                              input logic [7:0] hp, input logic [7:0] amp,
                              input logic nz);
    logic taken;
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {5'd0, nz, amp, hp, ch};
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    sent_by_type[req]++;
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_half_period();
    if ($urandom_range(0, 9) < 7) begin
      return 8'($urandom_range(0, 6));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Result side: random stall bursts whose density changes every 128 decisions,
  // plus one long hold-off on request.
  initial begin
    int stall_pct;
    int cyc;
    stall_pct = 0;
    cyc = 0;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (cyc % 128 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end
      cyc++;
      if (hold_output) begin
        hold_output = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int useful;
    int r;
    logic [2:0] req;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= REQ_TICK;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening.
    gap_pct = 30;
    send_request(REQ_TICK,    2'd3, 8'hff, 8'hff, 1'b1);
    send_request(REQ_WRITE,   2'd0, 8'd0,  8'd255, 1'b0);
    send_request(REQ_NOTE,    2'd0, 8'd0,  8'd0,   1'b0);
    send_request(REQ_TICK,    2'd0, 8'd0,  8'd0,   1'b0);
    send_request(REQ_TICK,    2'd0, 8'd0,  8'd0,   1'b0);
    send_request(REQ_WRITE,   2'd1, 8'd1,  8'd200, 1'b1);
    send_request(REQ_NOTE,    2'd1, 8'd0,  8'd0,   1'b0);
    send_request(REQ_TICK,    2'd0, 8'd0,  8'd0,   1'b0);
    send_request(REQ_TICK,    2'd0, 8'd0,  8'd0,   1'b0);
    send_request(REQ_WRITE,   2'd2, 8'd255, 8'd1,  1'b1);
    send_request(REQ_WRITE,   2'd3, 8'd8,  8'd128, 1'b0);
    send_request(REQ_NOTE,    2'd3, 8'd0,  8'd0,   1'b0);
    repeat (3) send_request(REQ_TICK, 2'd0, 8'd0, 8'd0, 1'b0);
    // Lowering the half period below the running count toggles on the next tick.
    send_request(REQ_WRITE,   2'd3, 8'd2,  8'd128, 1'b0);
    send_request(REQ_TICK,    2'd0, 8'd0,  8'd0,   1'b0);
    send_request(REQ_RETUNE,  2'd1, 8'd0,  8'd0,   1'b0);
    send_request(REQ_SILENCE, 2'd0, 8'd0,  8'd0,   1'b0);
    send_request(REQ_WRITE,   2'd2, 8'd0,  8'd0,   1'b1);
    send_request(REQ_TICK,    2'd0, 8'd0,  8'd0,   1'b0);
    send_request(REQ_SPARE_FIRST, 2'd3, 8'hff, 8'hff, 1'b1);
    send_request(REQ_SPARE_LAST,  2'd3, 8'hff, 8'hff, 1'b1);
    send_request(REQ_SILENCE, 2'd3, 8'd0,  8'd0,   1'b0);
    send_request(REQ_RETUNE,  2'd2, 8'd255, 8'd0,  1'b0);
    wait_for_results();

    // Random part.
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      if (useful % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          default: gap_pct = 40;
        endcase
      end
      if (useful == 400) begin
        hold_output = 1'b1;
      end
      if (useful == RANDOM_ITEMS - CALM_ITEMS) begin
        idle_on = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        req = REQ_TICK;
      end else if (r < 65) begin
        req = REQ_WRITE;
      end else if (r < 77) begin
        req = REQ_NOTE;
      end else if (r < 84) begin
        req = REQ_SILENCE;
      end else if (r < 95) begin
        req = REQ_RETUNE;
      end else begin
        req = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
      end
      if (req == REQ_WRITE) begin
        send_request(req, 2'($urandom_range(0, 3)), pick_half_period(),
                     ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                     1'($urandom_range(0, 1)));
      end else begin
        send_request(req, 2'($urandom_range(0, 3)), pick_half_period(),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      if (req <= REQ_RETUNE) begin
        useful++;
      end
    end

    wait_for_results();
    repeat (60) @(posedge clk);

    $display("Sent %0d ticks, %0d channel writes, %0d note starts, %0d silences,",
             sent_by_type[REQ_TICK], sent_by_type[REQ_WRITE], sent_by_type[REQ_NOTE],
             sent_by_type[REQ_SILENCE]);
    $display("%0d retunes and %0d unused codes; %0d results checked, %0d remixed, %0d bad.",
             sent_by_type[REQ_RETUNE],
             sent_by_type[5] + sent_by_type[6] + sent_by_type[7],
             results_checked, remix_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
